[src/caldate_pkg.sv]
`default_nettype none

package caldate_pkg;

	// Default calendar limits.
	localparam int EPOCH_YEAR_DEF = 1960;
	localparam int MAX_YEAR_DEF   = 9999;

	// Reciprocal of 400 for a 14-bit dividend: q = (p * RECIP_400) >> RECIP_SHIFT.
	localparam int RECIP_400   = 20972;
	localparam int RECIP_SHIFT = 23;

	// Item opcodes.
	localparam logic OP_LOAD    = 1'b0;
	localparam logic OP_ADVANCE = 1'b1;

	// Result status codes.
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_INVALID  = 2'd1;
	localparam logic [1:0] ST_BEFORE   = 2'd2;
	localparam logic [1:0] ST_OVERFLOW = 2'd3;

	// Controller states.
	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_LD_REM,
		S_LD_CHK,
		S_LD_COMMIT,
		S_ADV_MONTH,
		S_ADV_YEAR,
		S_DONE
	} ctrl_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic ld_div;
		logic ld_rem;
		logic ld_chk;
		logic ld_commit;
		logic adv_month;
		logic adv_year;
		logic out_load;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic op_adv;
		logic left_zero;
		logic month_final;
		logic month_wrap;
		logic year_fits;
	} dp_sts_t;

	// Days in a month, including the leap day of February.
	function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
		logic [4:0] len;
		case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                      len = 5'd30;
			4'd2:                                         len = leap ? 5'd29 : 5'd28;
			default:                                      len = 5'd0;
		endcase
		return len;
	endfunction

	// Days in the year before the first of a month, not counting the leap day.
	function automatic logic [8:0] month_start(input logic [3:0] m);
		logic [8:0] s;
		case (m)
			4'd1:    s = 9'd0;
			4'd2:    s = 9'd31;
			4'd3:    s = 9'd59;
			4'd4:    s = 9'd90;
			4'd5:    s = 9'd120;
			4'd6:    s = 9'd151;
			4'd7:    s = 9'd181;
			4'd8:    s = 9'd212;
			4'd9:    s = 9'd243;
			4'd10:   s = 9'd273;
			4'd11:   s = 9'd304;
			4'd12:   s = 9'd334;
			default: s = 9'd0;
		endcase
		return s;
	endfunction

	// Ordinal day within the year.
	function automatic logic [8:0] ordinal(input logic [4:0] d, input logic [3:0] m,
			input logic leap);
		logic extra;
		extra = leap && (m > 4'd2);
		return month_start(m) + 9'(d) + 9'(extra);
	endfunction

	// Leap rule from the year's residues modulo 4, 100 and 400.
	function automatic logic leap_from(input logic [1:0] m4, input logic [6:0] m100,
			input logic [8:0] m400);
		return (m4 == 2'd0) && ((m100 != 7'd0) || (m400 == 9'd0));
	endfunction

	// Residue modulo 7 by folding octal digits, since 8 is 1 modulo 7.
	function automatic logic [2:0] mod7(input logic [15:0] v);
		logic [5:0] s1;
		logic [3:0] s2;
		logic [2:0] s3;
		s1 = 6'(v[2:0]) + 6'(v[5:3]) + 6'(v[8:6]) + 6'(v[11:9]) + 6'(v[14:12])
			+ 6'(v[15]);
		s2 = 4'(s1[2:0]) + 4'(s1[5:3]);
		s3 = s2[2:0] + 3'(s2[3]);
		return (s3 == 3'd7) ? 3'd0 : s3;
	endfunction

endpackage

`default_nettype wire

[src/caldate_ctrl.sv]
`default_nettype none

module caldate_ctrl (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	input  wire caldate_pkg::dp_sts_t  sts,
	output caldate_pkg::dp_cmd_t       cmd
);
	import caldate_pkg::*;

	ctrl_state_t state_q, state_d;
	logic        out_valid_q;

	// State register and output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Next state and datapath commands.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_DECODE;
				end
			end
			S_DECODE: begin
				if (sts.op_adv) begin
					state_d = S_ADV_MONTH;
				end else begin
					cmd.ld_div = 1'b1;
					state_d    = S_LD_REM;
				end
			end
			S_LD_REM: begin
				cmd.ld_rem = 1'b1;
				state_d    = S_LD_CHK;
			end
			S_LD_CHK: begin
				cmd.ld_chk = 1'b1;
				state_d    = S_LD_COMMIT;
			end
			S_LD_COMMIT: begin
				cmd.ld_commit = 1'b1;
				state_d       = S_DONE;
			end
			S_ADV_MONTH: begin
				if (sts.left_zero) begin
					state_d = S_DONE;
				end else begin
					cmd.adv_month = 1'b1;
					if (sts.month_final) begin
						state_d = S_DONE;
					end else if (sts.month_wrap) begin
						state_d = S_ADV_YEAR;
					end
				end
			end
			S_ADV_YEAR: begin
				if (sts.year_fits) begin
					cmd.adv_year = 1'b1;
				end else begin
					state_d = S_ADV_MONTH;
				end
			end
			S_DONE: begin
				if (!out_valid_q || !out_stall) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

`ifndef ASSERT_OFF
	// A result appears only after the finishing state.
	a_result_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_DONE))
		else $error("result raised outside the finishing state");

	// Whole-year stepping is only entered from month stepping.
	a_year_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ADV_YEAR) |-> ($past(state_q) == S_ADV_MONTH
			|| $past(state_q) == S_ADV_YEAR))
		else $error("year stepping entered from an unexpected state");
`endif

endmodule

`default_nettype wire

[src/caldate_dp.sv]
`default_nettype none

module caldate_dp #(
	parameter int EPOCH_YEAR = caldate_pkg::EPOCH_YEAR_DEF,
	parameter int MAX_YEAR   = caldate_pkg::MAX_YEAR_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire caldate_pkg::dp_cmd_t  cmd,
	output caldate_pkg::dp_sts_t       sts,
	input  wire logic                  op,
	input  wire logic [4:0]            load_day,
	input  wire logic [3:0]            load_month,
	input  wire logic [13:0]           load_year,
	input  wire logic [15:0]           day_count,
	output logic [4:0]                 cur_day,
	output logic [3:0]                 cur_month,
	output logic [13:0]                cur_year,
	output logic [2:0]                 cur_weekday,
	output logic [8:0]                 day_of_year,
	output logic                       is_leap,
	output logic [1:0]                 status
);
	import caldate_pkg::*;

	// Reset date: 1 January of the epoch year.
	localparam int EP_PREV   = EPOCH_YEAR - 1;
	localparam int EP_WDAY   = (1 + 5 * (EP_PREV % 4) + 4 * (EP_PREV % 100)
		+ 6 * (EP_PREV % 400)) % 7;
	localparam int EP_MOD100 = EPOCH_YEAR % 100;
	localparam int EP_MOD400 = EPOCH_YEAR % 400;
	localparam int EP_LEAP   = ((EPOCH_YEAR % 400 == 0)
		|| ((EPOCH_YEAR % 4 == 0) && (EPOCH_YEAR % 100 != 0))) ? 1 : 0;

	localparam logic [13:0] EPOCH_Y = 14'(EPOCH_YEAR);
	localparam logic [13:0] MAX_Y   = 14'(MAX_YEAR);

	// Captured item.
	logic        op_q;
	logic [4:0]  ld_day_q;
	logic [3:0]  ld_month_q;
	logic [13:0] ld_year_q;
	logic [15:0] left_q;

	// Load working registers.
	logic [5:0]  q400_q;
	logic [8:0]  r400_q;
	logic [6:0]  r100_q;
	logic [2:0]  jan1_q;
	logic        new_leap_q;
	logic [1:0]  st_q;

	// Calendar state.
	logic [4:0]  day_q;
	logic [3:0]  month_q;
	logic [13:0] year_q;
	logic [2:0]  wday_q;
	logic        leap_q;
	logic [6:0]  m100_q;
	logic [8:0]  m400_q;

	// Load arithmetic on p = year - 1.
	logic [13:0] prev_y;
	logic [28:0] recip_prod;
	logic [13:0] q_times_400;
	logic [8:0]  r400_d;
	logic [6:0]  r100_d;
	logic [15:0] jan1_sum;
	logic [1:0]  ld_status;
	logic        ld_leap;

	assign prev_y      = ld_year_q - 14'd1;
	assign recip_prod  = 29'(prev_y) * 29'(RECIP_400);
	assign q_times_400 = 14'(q400_q) * 14'd400;
	assign r400_d      = 9'(prev_y - q_times_400);

	// Remainder modulo 100 of a value below 400.
	always_comb begin
		priority if (r400_d >= 9'd300) begin
			r100_d = 7'(r400_d - 9'd300);
		end else if (r400_d >= 9'd200) begin
			r100_d = 7'(r400_d - 9'd200);
		end else if (r400_d >= 9'd100) begin
			r100_d = 7'(r400_d - 9'd100);
		end else begin
			r100_d = 7'(r400_d);
		end
	end

	// The loaded year is leap when p ends a four-year group and is not a plain century.
	assign ld_leap  = (prev_y[1:0] == 2'd3) && ((r100_q != 7'd99) || (r400_q == 9'd399));
	assign jan1_sum = 16'd1 + 16'(prev_y[1:0]) * 16'd5 + 16'(r100_q) * 16'd4
		+ 16'(r400_q) * 16'd6;

	// Validation of the loaded date.
	always_comb begin
		priority if (ld_year_q < EPOCH_Y) begin
			ld_status = ST_BEFORE;
		end else if ((ld_month_q == 4'd0) || (ld_month_q > 4'd12) || (ld_year_q > MAX_Y)
				|| (ld_day_q == 5'd0)) begin
			ld_status = ST_INVALID;
		end else if (ld_day_q > month_days(ld_month_q, ld_leap)) begin
			ld_status = ST_INVALID;
		end else begin
			ld_status = ST_OK;
		end
	end

	// Month stepping.
	logic [4:0]  cur_len;
	logic [5:0]  to_next;
	logic        left_lt;
	logic        saturate;
	logic [8:0]  year_len;

	assign cur_len  = month_days(month_q, leap_q);
	assign to_next  = 6'(cur_len) - 6'(day_q) + 6'd1;
	assign left_lt  = left_q < 16'(to_next);
	assign saturate = (month_q == 4'd12) && (year_q >= MAX_Y);
	assign year_len = leap_q ? 9'd366 : 9'd365;

	// Residues of the following year.
	logic [13:0] year_inc;
	logic [6:0]  m100_inc;
	logic [8:0]  m400_inc;
	logic        leap_inc;

	assign year_inc = year_q + 14'd1;
	assign m100_inc = (m100_q == 7'd99) ? 7'd0 : m100_q + 7'd1;
	assign m400_inc = (m400_q == 9'd399) ? 9'd0 : m400_q + 9'd1;
	assign leap_inc = leap_from(year_inc[1:0], m100_inc, m400_inc);

	// Status to the controller.
	always_comb begin
		sts.op_adv      = (op_q == OP_ADVANCE);
		sts.left_zero   = (left_q == 16'd0);
		sts.month_final = left_lt || saturate;
		sts.month_wrap  = (month_q == 4'd12);
		sts.year_fits   = (left_q >= 16'(year_len)) && (year_q < MAX_Y);
	end

	// Captured item and load working registers.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q       <= op;
			ld_day_q   <= load_day;
			ld_month_q <= load_month;
			ld_year_q  <= load_year;
			left_q     <= day_count;
		end else if (cmd.adv_month) begin
			if (left_lt || saturate) begin
				left_q <= 16'd0;
			end else begin
				left_q <= left_q - 16'(to_next);
			end
		end else if (cmd.adv_year) begin
			left_q <= left_q - 16'(year_len);
		end
		if (cmd.ld_div) begin
			q400_q <= recip_prod[28:RECIP_SHIFT];
		end
		if (cmd.ld_rem) begin
			r400_q <= r400_d;
			r100_q <= r100_d;
		end
		if (cmd.ld_chk) begin
			jan1_q     <= mod7(jan1_sum);
			new_leap_q <= ld_leap;
		end
	end

	// Status of the current item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_OK;
		end else if (cmd.capture) begin
			st_q <= ST_OK;
		end else if (cmd.ld_chk) begin
			st_q <= ld_status;
		end else if (cmd.adv_month && !left_lt && saturate) begin
			st_q <= ST_OVERFLOW;
		end
	end

	// Calendar state updates.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			day_q   <= 5'd1;
			month_q <= 4'd1;
			year_q  <= EPOCH_Y;
			wday_q  <= 3'(EP_WDAY);
			leap_q  <= 1'(EP_LEAP);
			m100_q  <= 7'(EP_MOD100);
			m400_q  <= 9'(EP_MOD400);
		end else if (cmd.ld_commit) begin
			if (st_q == ST_OK) begin
				day_q   <= ld_day_q;
				month_q <= ld_month_q;
				year_q  <= ld_year_q;
				leap_q  <= new_leap_q;
				m100_q  <= (r100_q == 7'd99) ? 7'd0 : r100_q + 7'd1;
				m400_q  <= (r400_q == 9'd399) ? 9'd0 : r400_q + 9'd1;
				wday_q  <= mod7(16'(jan1_q)
					+ 16'(ordinal(ld_day_q, ld_month_q, new_leap_q)) - 16'd1);
			end
		end else if (cmd.adv_month) begin
			priority if (left_lt) begin
				day_q  <= day_q + left_q[4:0];
				wday_q <= mod7(16'(wday_q) + 16'(left_q[4:0]));
			end else if (saturate) begin
				day_q  <= 5'd31;
				wday_q <= mod7(16'(wday_q) + 16'(to_next) - 16'd1);
			end else begin
				day_q  <= 5'd1;
				wday_q <= mod7(16'(wday_q) + 16'(to_next));
				if (month_q == 4'd12) begin
					month_q <= 4'd1;
					year_q  <= year_inc;
					m100_q  <= m100_inc;
					m400_q  <= m400_inc;
					leap_q  <= leap_inc;
				end else begin
					month_q <= month_q + 4'd1;
				end
			end
		end else if (cmd.adv_year) begin
			wday_q <= mod7(16'(wday_q) + (leap_q ? 16'd2 : 16'd1));
			year_q <= year_inc;
			m100_q <= m100_inc;
			m400_q <= m400_inc;
			leap_q <= leap_inc;
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			cur_day     <= day_q;
			cur_month   <= month_q;
			cur_year    <= year_q;
			cur_weekday <= wday_q;
			day_of_year <= ordinal(day_q, month_q, leap_q);
			is_leap     <= leap_q;
			status      <= st_q;
		end
	end

`ifndef ASSERT_OFF
	// The held day always lies within its month.
	a_day_in_month: assert property (@(posedge clk) disable iff (!arst_n)
		(day_q >= 5'd1) && (day_q <= cur_len) && (month_q >= 4'd1) && (month_q <= 4'd12))
		else $error("calendar state holds an impossible date");

	// The leap flag agrees with the tracked year residues.
	a_leap_residues: assert property (@(posedge clk) disable iff (!arst_n)
		leap_q == leap_from(year_q[1:0], m100_q, m400_q))
		else $error("leap flag disagrees with year residues");

	// An overflow result always stands on 31 December.
	a_overflow_date: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.out_load && (st_q == ST_OVERFLOW)) |-> ((month_q == 4'd12) && (day_q == 5'd31)))
		else $error("overflow reported away from the last day of the year");
`endif

endmodule

`default_nettype wire

[src/calendar_date_counter_core.sv]
// A load item passes through the decode, remainder, check and commit states before its result
// is registered; an advance item steps once per month boundary crossed and once per whole year
// skipped, with one more step at each new year reached by month stepping.
// One item at a time: a new item is not accepted until the current one has finished.
// The next item is accepted while a finished result waits in the output register.
// Reset (arst_n low, asynchronous) sets 1 January of the epoch year (a Friday for the default
// epoch of 1960) and clears the output valid flag.
`default_nettype none

module calendar_date_counter_core #(
	parameter int EPOCH_YEAR = caldate_pkg::EPOCH_YEAR_DEF,
	parameter int MAX_YEAR   = caldate_pkg::MAX_YEAR_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        op,
	input  wire logic [4:0]  load_day,
	input  wire logic [3:0]  load_month,
	input  wire logic [13:0] load_year,
	input  wire logic [15:0] day_count,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [4:0]       cur_day,
	output logic [3:0]       cur_month,
	output logic [13:0]      cur_year,
	output logic [2:0]       cur_weekday,
	output logic [8:0]       day_of_year,
	output logic             is_leap,
	output logic [1:0]       status
);
	import caldate_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	// Sequencer for load and advance items.
	caldate_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Calendar state, arithmetic and result register.
	caldate_dp #(
		.EPOCH_YEAR (EPOCH_YEAR),
		.MAX_YEAR   (MAX_YEAR)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.op          (op),
		.load_day    (load_day),
		.load_month  (load_month),
		.load_year   (load_year),
		.day_count   (day_count),
		.cur_day     (cur_day),
		.cur_month   (cur_month),
		.cur_year    (cur_year),
		.cur_weekday (cur_weekday),
		.day_of_year (day_of_year),
		.is_leap     (is_leap),
		.status      (status)
	);

endmodule

`default_nettype wire
